// ----- rtl/mvf_pkg.sv -----
// Shared types and constants for the motor voltage feedforward unit.
// Used by mvf_ctrl, mvf_datapath and motor_voltage_feedforward_unit.
`default_nettype none

package mvf_pkg;

  localparam int unsigned InDataW  = 80;   // current 24, position 32, interval 24
  localparam int unsigned OutDataW = 96;   // voltage 32, velocity 32, rate 32
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_NOMINAL_PERIOD  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FILTER_GAIN     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FILTER_POLE     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_EMF_GAIN        = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RESISTANCE_GAIN = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_INDUCTANCE_GAIN = 3'd5;

  localparam logic [23:0] NominalPeriodReset = 24'd1000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE_GAIN,
    ST_RATE_POLE,
    ST_VEL_GAIN,
    ST_VEL_POLE,
    ST_VEL_SUM,
    ST_V_IND,
    ST_V_RES,
    ST_V_EMF,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    MUL_RATE_GAIN,
    MUL_RATE_POLE,
    MUL_VEL_GAIN,
    MUL_VEL_POLE,
    MUL_IND,
    MUL_RES,
    MUL_EMF
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef struct packed {
    logic     load_in;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     wr_rate;
    logic     wr_vel;
    logic     wr_hist;
    logic     wr_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_stall;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/mvf_ctrl.sv -----
// Sequencer for the motor voltage feedforward unit: steps the shared
// multiplier and accumulator through the two differentiators and the sum.
// Depends on mvf_pkg.
`default_nettype none

module mvf_ctrl
  import mvf_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_RATE_GAIN;
    cmd_o.acc_op  = ACC_HOLD;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_RATE_GAIN;
        end
      end
      ST_RATE_GAIN: begin
        cmd_o.mul_sel = MUL_RATE_GAIN;
        state_d       = ST_RATE_POLE;
      end
      ST_RATE_POLE: begin
        cmd_o.mul_sel = MUL_RATE_POLE;
        cmd_o.acc_op  = ACC_LOAD;
        state_d       = ST_VEL_GAIN;
      end
      ST_VEL_GAIN: begin
        cmd_o.mul_sel = MUL_VEL_GAIN;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_VEL_POLE;
      end
      ST_VEL_POLE: begin
        // current derivative sum is complete: round it and start position
        cmd_o.mul_sel = MUL_VEL_POLE;
        cmd_o.acc_op  = ACC_LOAD;
        cmd_o.wr_rate = 1'b1;
        state_d       = ST_VEL_SUM;
      end
      ST_VEL_SUM: begin
        cmd_o.mul_sel = MUL_IND;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_V_IND;
      end
      ST_V_IND: begin
        cmd_o.mul_sel = MUL_RES;
        cmd_o.acc_op  = ACC_LOAD;
        cmd_o.wr_vel  = 1'b1;
        cmd_o.wr_hist = 1'b1;
        state_d       = ST_V_RES;
      end
      ST_V_RES: begin
        cmd_o.mul_sel = MUL_EMF;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_V_EMF;
      end
      ST_V_EMF: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!sts_i.out_stall) begin
          cmd_o.wr_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/mvf_datapath.sv -----
// Datapath of the motor voltage feedforward unit: configuration registers,
// sample history, shared 33x33 multiplier, accumulator and output register.
// Depends on mvf_pkg.
`default_nettype none

module mvf_datapath
  import mvf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic [InDataW-1:0]  in_data_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic [OutDataW-1:0]      out_data_o,
  output logic                     out_ok_o,
  input  wire dp_cmd_t             cmd_i,
  output dp_sts_t                  sts_o
);

  // configuration
  logic [23:0]        period_q;
  logic [30:0]        gain_q;
  logic [16:0]        pole_q;
  logic signed [31:0] emf_q, res_q, ind_q;

  // item and history
  logic signed [23:0] cur_q, lcur_q;
  logic signed [31:0] pos_q, lpos_q;
  logic signed [31:0] lrate_q, lvel_q;
  logic               ok_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;
  logic signed [67:0] acc_q;
  logic signed [31:0] acc_sat;

  logic               out_valid_q;
  logic signed [31:0] out_volt_q, out_vel_q, out_rate_q;
  logic               out_ok_q;

  logic [23:0] in_dt;
  logic [27:0] ten_dt, nine_ts, eleven_ts;
  logic        in_ok;

  function automatic logic signed [31:0] round_sat(input logic signed [67:0] v);
    logic signed [67:0] t;
    logic signed [51:0] s;
    t = v + 68'sd32768;
    s = t[67:16];
    if (s > 52'sd2147483647) begin
      round_sat = 32'sh7fffffff;
    end else if (s < -52'sd2147483648) begin
      round_sat = 32'sh80000000;
    end else begin
      round_sat = s[31:0];
    end
  endfunction

  // window test on shifts and adds: 10*dt > 9*ts and 10*dt < 11*ts
  assign in_dt     = in_data_i[79:56];
  assign ten_dt    = ({4'b0, in_dt} << 3) + ({4'b0, in_dt} << 1);
  assign nine_ts   = ({4'b0, period_q} << 3) + {4'b0, period_q};
  assign eleven_ts = ({4'b0, period_q} << 3) + ({4'b0, period_q} << 1) + {4'b0, period_q};
  assign in_ok     = (ten_dt > nine_ts) && (ten_dt < eleven_ts);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= NominalPeriodReset;
      gain_q   <= '0;
      pole_q   <= '0;
      emf_q    <= '0;
      res_q    <= '0;
      ind_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NOMINAL_PERIOD:  period_q <= cfg_data_i[23:0];
        CFG_FILTER_GAIN:     gain_q   <= cfg_data_i[30:0];
        CFG_FILTER_POLE:     pole_q   <= cfg_data_i[16:0];
        CFG_EMF_GAIN:        emf_q    <= cfg_data_i;
        CFG_RESISTANCE_GAIN: res_q    <= cfg_data_i;
        CFG_INDUCTANCE_GAIN: ind_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_RATE_GAIN: begin
        mul_a = {2'b00, gain_q};
        mul_b = 33'(cur_q) - 33'(lcur_q);
      end
      MUL_RATE_POLE: begin
        mul_a = {16'b0, pole_q};
        mul_b = 33'(lrate_q);
      end
      MUL_VEL_GAIN: begin
        mul_a = {2'b00, gain_q};
        mul_b = 33'(pos_q) - 33'(lpos_q);
      end
      MUL_VEL_POLE: begin
        mul_a = {16'b0, pole_q};
        mul_b = 33'(lvel_q);
      end
      MUL_IND: begin
        mul_a = 33'(ind_q);
        mul_b = 33'(lrate_q);
      end
      MUL_RES: begin
        mul_a = 33'(res_q);
        mul_b = 33'(cur_q);
      end
      MUL_EMF: begin
        mul_a = 33'(emf_q);
        mul_b = 33'(lvel_q);
      end
      default: ;
    endcase
  end

  assign acc_sat = round_sat(acc_q);

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.acc_op)
      ACC_LOAD: acc_q <= 68'(prod_q);
      ACC_ADD:  acc_q <= acc_q + 68'(prod_q);
      default:  acc_q <= acc_q;
    endcase
    if (cmd_i.load_in) begin
      cur_q <= in_data_i[23:0];
      pos_q <= in_data_i[55:24];
    end
    if (cmd_i.wr_out) begin
      out_volt_q <= acc_sat;
      out_vel_q  <= lvel_q;
      out_rate_q <= lrate_q;
      out_ok_q   <= ok_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcur_q      <= '0;
      lpos_q      <= '0;
      lrate_q     <= '0;
      lvel_q      <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_in) begin
        ok_q <= in_ok;
      end
      // hold the derivatives when the interval is outside the window
      if (cmd_i.wr_rate && ok_q) begin
        lrate_q <= acc_sat;
      end
      if (cmd_i.wr_vel && ok_q) begin
        lvel_q <= acc_sat;
      end
      if (cmd_i.wr_hist) begin
        lcur_q <= cur_q;
        lpos_q <= pos_q;
      end
      if (cmd_i.wr_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = {out_rate_q, out_vel_q, out_volt_q};
  assign out_ok_o        = out_ok_q;

endmodule

`default_nettype wire

// ----- rtl/motor_voltage_feedforward_unit.sv -----
// Motor voltage feedforward unit, one joint: top level joining the sequencer
// and the datapath. Depends on mvf_pkg, mvf_ctrl and mvf_datapath.
//
// Usage:
//   s_axis carries one motor sample per transaction: measured current,
//   position and the ticks since the previous sample. m_axis returns one
//   result per sample: drive voltage, velocity, current rate and, in tuser,
//   the timing flag (derivatives updated this sample).
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while
//   the unit is idle; indexes above five are ignored.
//   The unit works on one sample at a time, as the seven products
//   share one 33x33 multiplier and the accumulator behind it.
//   The unit takes the next sample while a finished result still waits on
//   m_axis; if the receiver stalls, that next result holds in the last step
//   until the output register is free.
//   Reset: registers return to their defaults (nominal period 1000, all
//   gains zero) and the sample history and derivatives clear to zero.
`default_nettype none

module motor_voltage_feedforward_unit
  import mvf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // current_sample[23:0], position_sample[55:24], interval_ticks[79:56]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // drive_voltage[31:0], velocity[63:32], current_rate[95:64]
  output logic [OutDataW-1:0]      m_axis_tdata,
  // timing_ok[0]
  output logic                     m_axis_tuser
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mvf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mvf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_ok_o    (m_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // a sample in flight blocks the next one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a sample is in flight");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_out |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result written over a stalled result");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_out |-> !s_axis_tready)
    else $error("result written while the sequencer is idle");

  a_history_before_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_hist |-> !cmd.load_in && !cmd.wr_out)
    else $error("history update overlaps load or output write");

endmodule

`default_nettype wire
